// ----- hdl/pcm_pkg.sv -----
// Shared constants and types for the PCM sample converter.
`default_nettype none
package pcm_pkg;
    localparam int unsigned FmtW = 3;
    localparam logic [FmtW-1:0] FMT_INT16   = 3'd0;
    localparam logic [FmtW-1:0] FMT_INT24   = 3'd1;
    localparam logic [FmtW-1:0] FMT_INT32   = 3'd2;
    localparam logic [FmtW-1:0] FMT_FLOAT32 = 3'd3;

    localparam logic [15:0] PCM_MAX = 16'sd32767;
    localparam logic [15:0] PCM_MIN = 16'h8001;

    // Stage-one result carried to the multiply stage.
    typedef struct packed {
        logic        sel_raw;   // Integer format or silence: use raw value.
        logic [15:0] raw;
        logic        sign;
        logic [7:0]  expo;
        logic [23:0] mant;      // With hidden bit.
        logic        is_zero;   // NaN, zero or too small for the scale.
        logic        is_sat;    // Magnitude at or above one.
        logic        last;
    } pcm_stage_t;
endpackage
`default_nettype wire

// ----- hdl/pcm_decode.sv -----
// First stage: decodes the format and unpacks the float fields.
`default_nettype none
module pcm_decode (
    input  wire logic [pcm_pkg::FmtW-1:0] fmt,
    input  wire logic [31:0]              word,
    input  wire logic                     last,
    output pcm_pkg::pcm_stage_t           st
);
    logic [7:0]  e;
    logic [22:0] f;

    always_comb
    begin
        e = word[30:23];
        f = word[22:0];
        st = '0;
        st.last = last;
        st.sign = word[31];
        st.expo = e;
        st.mant = {1'b1, f};
        case (fmt)
            pcm_pkg::FMT_INT16:   begin st.sel_raw = 1'b1; st.raw = word[15:0];  end
            pcm_pkg::FMT_INT24:   begin st.sel_raw = 1'b1; st.raw = word[23:8];  end
            pcm_pkg::FMT_INT32:   begin st.sel_raw = 1'b1; st.raw = word[31:16]; end
            pcm_pkg::FMT_FLOAT32:
            begin
                st.sel_raw = 1'b0;
                // Values below 2^-16 scale to below one half and truncate to zero.
                st.is_zero = ((e == 8'hFF) && (f != 23'd0)) || (e < 8'd111);
                st.is_sat  = !st.is_zero && (e >= 8'd127);
            end
            default:              begin st.sel_raw = 1'b1; st.raw = 16'd0; end
        endcase
    end
endmodule
`default_nettype wire

// ----- hdl/pcm_scale.sv -----
// Second stage: single-precision multiply by 32767, rounding, truncation.
`default_nettype none
module pcm_scale (
    input  wire pcm_pkg::pcm_stage_t st,
    output logic [15:0]              pcm
);
    logic [38:0] prod;      // mant * 32767, at most 39 bits.
    logic [38:0] rnd;
    logic [5:0]  sh;        // Right shift that drops product to 24 significant bits.
    logic [38:0] keep;
    logic [38:0] rem;
    logic [38:0] half;
    logic [38:0] sig;
    logic [15:0] mag;
    logic [7:0]  lsb_pos;   // Bit weight of the float result lsb relative to 2^0.
    logic [6:0]  ip;

    always_comb
    begin
        prod = 39'(st.mant) * 39'd32767;
        // prod has its msb at bit 38 or 37; keep 24 bits.
        sh   = prod[38] ? 6'd15 : 6'd14;
        keep = prod >> sh;
        rem  = prod & ((39'd1 << sh) - 39'd1);
        half = 39'd1 << (sh - 6'd1);
        rnd  = keep;
        if ((rem > half) || ((rem == half) && keep[0]))
        begin
            rnd = keep + 39'd1;
        end
        // Value = rnd * 2^(expo-127-23+sh); integer part is rnd >> (150-expo-sh).
        lsb_pos = 8'd150 - st.expo - {2'b0, sh};
        ip  = lsb_pos[6:0];
        sig = rnd >> ip;
        mag = sig[15:0];
        if (st.sel_raw)
        begin
            pcm = st.raw;
        end
        else if (st.is_zero)
        begin
            pcm = 16'd0;
        end
        else if (st.is_sat)
        begin
            pcm = st.sign ? pcm_pkg::PCM_MIN : pcm_pkg::PCM_MAX;
        end
        else
        begin
            pcm = st.sign ? (16'd0 - mag) : mag;
        end
    end
endmodule
`default_nettype wire

// ----- hdl/pcm_sample_to_int16_converter.sv -----
// Top level of the PCM sample converter: handshake, pipeline registers, config.
//
//  channel | dir | contents
//  s_axis  | in  | tdata = sample_word[31:0], tlast = last_in_block
//  m_axis  | out | tdata = pcm_sample[15:0], tlast = last_out
//  cfg     | in  | sample_format[2:0] written when cfg_we is high
//
// One word is accepted per cycle while m_axis does not stall. A word passes the decode
// register, then the result register with the multiplier between, and shows on m_axis
// once it sits in the result register.
// Reset clears the format to int16 and empties both stages.
// A stall on m_axis holds the result; each stage advances when the one after it
// is empty or being emptied, so without a stall throughput stays at one word per cycle.
`default_nettype none
module pcm_sample_to_int16_converter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_wdata,      // sample_format
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // sample_word
    input  wire logic        s_axis_tlast,   // last_in_block
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [15:0] m_axis_tdata,   // pcm_sample
    output      logic        m_axis_tlast    // last_out
);
    logic [pcm_pkg::FmtW-1:0] fmt_reg;
    pcm_pkg::pcm_stage_t st_next, st_reg;
    logic        v1_reg, v2_reg;
    logic [15:0] pcm_next, pcm_reg;
    logic        last_reg;
    logic        adv2, adv1;

    pcm_decode u_dec (.fmt(fmt_reg), .word(s_axis_tdata), .last(s_axis_tlast), .st(st_next));
    pcm_scale  u_scl (.st(st_reg), .pcm(pcm_next));

    assign adv2 = !v2_reg || m_axis_tready;
    assign adv1 = !v1_reg || adv2;
    assign s_axis_tready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= pcm_pkg::FMT_INT16;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                fmt_reg <= cfg_wdata;
            end
            if (adv1)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && s_axis_tvalid)
        begin
            st_reg <= st_next;
        end
        if (adv2 && v1_reg)
        begin
            pcm_reg  <= pcm_next;
            last_reg <= st_reg.last;
        end
    end

    assign m_axis_tvalid = v2_reg;
    assign m_axis_tdata  = pcm_reg;
    assign m_axis_tlast  = last_reg;

    // A held result must not change while stalled.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    // A decoded word moves to the output stage when it is free.
    a_move: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !v2_reg |=> v2_reg)
        else $error("stage one word not advanced");
    // Ready is withheld only when both stages are full and the output stalls.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> v1_reg && v2_reg && !m_axis_tready)
        else $error("ready dropped without backpressure");
endmodule
`default_nettype wire

// ----- tb/pcm_sample_to_int16_converter_tb.sv -----
// Self-checking testbench for the PCM sample converter: every format, float edge cases, stalls.
`default_nettype none
module pcm_sample_to_int16_converter_tb;
    typedef logic [pcm_pkg::FmtW-1:0] fmt_t;

    // The package names the four real formats; the silence codes are local here.
    localparam fmt_t FMT_SILENT = 3'd4;
    localparam fmt_t FMT_TOP    = 3'd7;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [15:0] pcm;
        logic        last;
    } pcm_word_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;    // sample_word
    logic        s_axis_tlast;    // last_in_block
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;    // pcm_sample
    logic        m_axis_tlast;    // last_out

    pcm_word_t      pending_pcm[$];
    fmt_t           cur_fmt;
    int             src_idle;
    int             rx_idle;
    int             mismatches;
    int             words_sent;
    int             words_checked;
    int             cycles;
    int             hold_cnt;
    bit             hold_req;
    bit             hold_done;

    pcm_sample_to_int16_converter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Float32 to int16: clamp to [-1,1], multiply by 32767 with round to
    // nearest even at 24 significant bits, then truncate toward zero. All of
    // it is done in integers so no simulator float support is needed.
    function automatic logic [15:0] float_to_pcm16(input logic [31:0] bits);
        logic        sgn;
        int          ex;
        longint      mant;
        longint      prod;
        longint      q;
        longint      rem;
        longint      half;
        longint      mag;
        int          k;
        int          len;
        int          sh;
        int          ep;
        sgn = bits[31];
        ex = int'(bits[30:23]);
        if (ex == 255 && bits[22:0] != 0)
            return 16'd0;                      // NaN is silent
        if (ex >= 127)
        begin
            // Magnitude at or above one, infinities included: saturate.
            mag = 32767;
        end
        else
        begin
            if (ex == 0)
            begin
                mant = longint'(bits[22:0]);
                k = -149;
            end
            else
            begin
                mant = longint'({1'b1, bits[22:0]});
                k = ex - 150;
            end
            prod = mant * 32767;
            len = 0;
            for (int i = 0; i < 63; i++)
                if (prod[i])
                    len = i + 1;
            sh = 0;
            q = prod;
            if (len > 24)
            begin
                sh = len - 24;
                q = prod >> sh;
                rem = prod & ((64'd1 << sh) - 1);
                half = 64'd1 << (sh - 1);
                if (rem > half || (rem == half && q[0]))
                    q = q + 1;
            end
            ep = k + sh;
            if (ep >= 0)
                mag = q << ep;
            else if (-ep >= 60)
                mag = 0;
            else
                mag = q >> (-ep);
        end
        if (sgn)
            mag = -mag;
        return mag[15:0];
    endfunction

    function automatic logic [15:0] convert_sample(input fmt_t fmt,
                                                   input logic [31:0] word);
        case (fmt)
            pcm_pkg::FMT_INT16:   return word[15:0];
            pcm_pkg::FMT_INT24:   return word[23:8];
            pcm_pkg::FMT_INT32:   return word[31:16];
            pcm_pkg::FMT_FLOAT32: return float_to_pcm16(word);
            default:              return 16'd0;
        endcase
    endfunction

    // Offers one word after a random gap and returns at the edge that took it.
    // The valid stays high on return so back-to-back words need no toggle.
    task automatic send_sample(input logic [31:0] word, input logic last);
        pcm_word_t exp_w;
        while ($urandom_range(99) < src_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        exp_w.pcm  = convert_sample(cur_fmt, word);
        exp_w.last = last;
        pending_pcm.push_back(exp_w);
        words_sent++;
    endtask

    // Waits until every expected word has come out, then lets the pipeline settle.
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_pcm.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_format(input fmt_t fmt);
        drain_pipeline();
        cfg_we    <= 1'b1;
        cfg_wdata <= fmt;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_fmt = fmt;
        @(posedge clk);
    endtask

    // Random float words: mostly in range, plus raw bits and special values.
    function automatic logic [31:0] random_float_word();
        int pick;
        pick = $urandom_range(9);
        if (pick < 5)
            return {1'($urandom), 8'($urandom_range(127, 100)), 23'($urandom)};
        else if (pick < 8)
            return $urandom;
        else if (pick == 8)
            return {1'($urandom), 8'hFF, 23'($urandom_range(1))};
        else
            return {1'($urandom), 8'h7F, 23'($urandom_range(3))};
    endfunction

    task automatic test_integer_formats();
        write_format(pcm_pkg::FMT_INT16);
        send_sample(32'hABCD_0000, 1'b0);
        send_sample(32'h1234_7FFF, 1'b1);
        send_sample(32'h0000_8000, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b1);
        write_format(pcm_pkg::FMT_INT24);
        send_sample(32'hFF7F_FFFF, 1'b0);
        send_sample(32'h0080_0000, 1'b1);
        send_sample(32'h0000_00FF, 1'b0);
        write_format(pcm_pkg::FMT_INT32);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b1);
        send_sample(32'h0000_FFFF, 1'b0);
    endtask

    task automatic test_float_edges();
        write_format(pcm_pkg::FMT_FLOAT32);
        send_sample(32'h3F80_0000, 1'b0);    // +1.0
        send_sample(32'hBF80_0000, 1'b0);    // -1.0
        send_sample(32'h3F00_0000, 1'b0);    // 0.5
        send_sample(32'h3F7F_FFFF, 1'b0);    // just under one
        send_sample(32'h7FC0_0000, 1'b1);    // NaN
        send_sample(32'h7F80_0000, 1'b0);    // +inf
        send_sample(32'hFF80_0000, 1'b0);    // -inf
        send_sample(32'hC000_0000, 1'b0);    // -2.0, clamped
        send_sample(32'h8000_0000, 1'b0);    // negative zero
        send_sample(32'h0000_0001, 1'b1);    // smallest denormal
    endtask

    task automatic test_silence_codes();
        write_format(FMT_SILENT);
        send_sample(32'h7FFF_FFFF, 1'b1);
        send_sample(32'h8000_8000, 1'b0);
        write_format(FMT_TOP);
        send_sample(32'hFFFF_FFFF, 1'b1);
    endtask

    // Random words in chunks, each chunk under a randomly chosen format.
    task automatic test_random_stream(input int count);
        logic [31:0] word;
        int left;
        left = count;
        while (left > 0)
        begin
            write_format(fmt_t'($urandom_range(9) < 8 ? $urandom_range(3)
                                                      : $urandom_range(7, 4)));
            for (int i = 0; i < 40 && left > 0; i++)
            begin
                word = (cur_fmt == pcm_pkg::FMT_FLOAT32) ? random_float_word() : $urandom;
                send_sample(word, 1'($urandom_range(7) == 0));
                left--;
            end
        end
    endtask

    // The receiver stops for a long stretch while words keep coming, so the
    // pipeline fills and the input must stall.
    task automatic test_output_stall();
        write_format(pcm_pkg::FMT_INT32);
        src_idle = 0;
        rx_idle  = 0;
        hold_req = 1'b1;
        for (int i = 0; i < 20; i++)
            send_sample($urandom, 1'($urandom));
    endtask

    // Hold-off counter for the receiver, started once on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_cnt  <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // Result checker and receiver ready.
    always @(posedge clk or negedge rst_n)
    begin
        pcm_word_t exp_w;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_pcm.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: pcm %h last %b", m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    exp_w = pending_pcm.pop_front();
                    words_checked++;
                    if (exp_w.pcm !== m_axis_tdata || exp_w.last !== m_axis_tlast)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected pcm %h last %b, got pcm %h last %b",
                                     exp_w.pcm, exp_w.last, m_axis_tdata, m_axis_tlast);
                    end
                end
            end
            if (hold_cnt > 0)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // A hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycles, pending_pcm.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cur_fmt       = pcm_pkg::FMT_INT16;
        src_idle      = 0;
        rx_idle       = 0;
        words_sent    = 0;
        hold_req      = 1'b0;
        repeat (6) @(posedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // The reset format is int16, so a word goes through before any write.
        send_sample(32'hDEAD_BEEF, 1'b1);
        src_idle = 12;
        rx_idle  = 82;
        test_integer_formats();
        test_float_edges();
        test_silence_codes();
        test_random_stream(200);
        src_idle = 82;
        rx_idle  = 12;
        test_random_stream(200);
        src_idle = 0;
        rx_idle  = 0;
        test_random_stream(200);
        test_output_stall();
        drain_pipeline();

        $display("sent %0d words, checked %0d, across integer, float and silence formats",
                 words_sent, words_checked);
        $display("float edge cases, both idling mixes and a long output stall included");
        if (mismatches == 0 && pending_pcm.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
